[hw/rtl/fvc_pkg.sv]
package fvc_pkg;

  localparam int RampSteps = 15;
  localparam int RingSize  = 6 * RampSteps;
  localparam int KW        = $clog2(RingSize);

  localparam logic [15:0] MaxRadiusReset = 16'd7680;
  localparam logic [23:0] OneByteQ16     = 24'hFF0000;
  localparam logic [15:0] HalfTurn       = 16'h8000;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 24;
  localparam int DivSteps    = 17;

  localparam logic [19:0] CordicTurns [CordicSteps] = '{
    20'd131072, 20'd77376, 20'd40884, 20'd20753, 20'd10417, 20'd5213, 20'd2607, 20'd1304,
    20'd652, 20'd326, 20'd163, 20'd81, 20'd41, 20'd20, 20'd10, 20'd5
  };

  typedef struct packed {
    logic valid;
    logic unknown;
    logic last;
    logic yzero;
    logic xneg;
    logic in_circle;
  } meta_t;

  // Hue ring entry k, packed as {blue, green, red}.
  function automatic logic [23:0] ring_rgb(input logic [KW-1:0] k);
    int   seg;
    int   up;
    logic [7:0] u;
    logic [7:0] d;
    logic [23:0] res;
    seg = (int'(k) / RampSteps) % 6;
    up  = (255 * (int'(k) % RampSteps)) / RampSteps;
    u   = 8'(up);
    d   = 8'(255 - up);
    case (seg)
      0: res = {8'd0, u, 8'd255};
      1: res = {8'd0, 8'd255, d};
      2: res = {u, 8'd255, 8'd0};
      3: res = {8'd255, d, 8'd0};
      4: res = {8'd255, 8'd0, u};
      default: res = {d, 8'd0, 8'd255};
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/fvc_cordic_cell.sv]
module fvc_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               ce,
  input  logic signed [31:0] cx_in,
  input  logic signed [31:0] cy_in,
  input  logic [19:0]        acc_in,
  output logic signed [31:0] cx,
  output logic signed [31:0] cy,
  output logic [19:0]        acc
);
  import fvc_pkg::*;

  logic signed [31:0] dx;
  logic signed [31:0] dy;

  assign dx = cy_in >>> STAGE;
  assign dy = cx_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (!cy_in[31]) begin
        cx  <= cx_in + dx;
        cy  <= cy_in - dy;
        acc <= acc_in + CordicTurns[STAGE];
      end else begin
        cx  <= cx_in - dx;
        cy  <= cy_in + dy;
        acc <= acc_in - CordicTurns[STAGE];
      end
    end
  end

endmodule

[hw/rtl/fvc_sqrt_cell.sv]
module fvc_sqrt_cell (
  input  logic        clk,
  input  logic        ce,
  input  logic [47:0] bits_in,
  input  logic [25:0] rem_in,
  input  logic [23:0] root_in,
  output logic [47:0] bits,
  output logic [25:0] rem,
  output logic [23:0] root
);

  logic [27:0] cur;
  logic [27:0] trial;

  assign cur   = {rem_in, bits_in[47:46]};
  assign trial = {2'b00, root_in, 2'b01};

  always_ff @(posedge clk) begin
    if (ce) begin
      bits <= {bits_in[45:0], 2'b00};
      if (cur >= trial) begin
        rem  <= 26'(cur - trial);
        root <= {root_in[22:0], 1'b1};
      end else begin
        rem  <= cur[25:0];
        root <= {root_in[22:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/fvc_div_cell.sv]
module fvc_div_cell (
  input  logic        clk,
  input  logic        ce,
  input  logic [15:0] divisor,
  input  logic [16:0] bits_in,
  input  logic [15:0] rem_in,
  input  logic [16:0] q_in,
  output logic [16:0] bits,
  output logic [15:0] rem,
  output logic [16:0] q
);

  logic [16:0] cur;

  assign cur = {rem_in, bits_in[16]};

  always_ff @(posedge clk) begin
    if (ce) begin
      bits <= {bits_in[15:0], 1'b0};
      if (cur >= {1'b0, divisor}) begin
        rem <= 16'(cur - {1'b0, divisor});
        q   <= {q_in[15:0], 1'b1};
      end else begin
        rem <= cur[15:0];
        q   <= {q_in[15:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/fvc_shade.sv]
module fvc_shade (
  input  logic        clk,
  input  logic        ce,
  input  logic [15:0] turn,
  input  logic [16:0] rad,
  input  logic        in_circle,
  input  logic        unknown,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import fvc_pkg::*;

  logic [15+KW:0] fk;
  logic [KW-1:0]  k0;
  logic [KW-1:0]  k1;
  logic [15:0]    f;
  logic [16:0]    r1;
  logic           in1;
  logic           unk1;

  logic [23:0]    hue [RingSize];
  logic [23:0]    e0;
  logic [23:0]    e1;
  logic [23:0]    c2 [3];
  logic [16:0]    r2;
  logic           in2;
  logic           unk2;

  logic [23:0]    c3 [3];
  logic [23:0]    d3 [3];
  logic           in3;
  logic           unk3;

  for (genvar k = 0; k < RingSize; k++) begin : g_hue
    assign hue[k] = ring_rgb(KW'(k));
  end

  assign fk = (16+KW)'(turn) * (16+KW)'(RingSize - 1);
  assign e0 = hue[k0];
  assign e1 = hue[k1];

  always_ff @(posedge clk) begin
    if (ce) begin
      k0   <= fk[15+KW:16];
      k1   <= (fk[15+KW:16] == KW'(RingSize - 1)) ? '0 : KW'(fk[15+KW:16] + 1'b1);
      f    <= fk[15:0];
      r1   <= rad;
      in1  <= in_circle;
      unk1 <= unknown;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int ch = 0; ch < 3; ch++) begin
        c2[ch] <= 24'((25'(17'h10000 - {1'b0, f}) * 25'(e0[ch*8 +: 8]))
                    + (25'(f) * 25'(e1[ch*8 +: 8])));
      end
      r2   <= r1;
      in2  <= in1;
      unk2 <= unk1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int ch = 0; ch < 3; ch++) begin
        c3[ch] <= c2[ch];
        d3[ch] <= 24'(((41'(r2) * 41'(OneByteQ16 - c2[ch])) >> 16));
      end
      in3  <= in2;
      unk3 <= unk2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (unk3) begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end else if (in3) begin
        red   <= 8'((OneByteQ16 - d3[0]) >> 16);
        green <= 8'((OneByteQ16 - d3[1]) >> 16);
        blue  <= 8'((OneByteQ16 - d3[2]) >> 16);
      end else begin
        red   <= c3[0][23:16];
        green <= c3[1][23:16];
        blue  <= c3[2][23:16];
      end
    end
  end

endmodule

[hw/rtl/flow_vector_to_color_core.sv]
// Throughput: one pixel per cycle unless the output stalls; the 24-cell square root
// row and the 17-cell divider row behind it set the depth, the 16-cell CORDIC row runs
// beside them. The whole pipeline holds while an output waits and m_tready is low.
// Reset clears all valid flags and loads max_radius with 7680 (30.0 pixels).
module flow_vector_to_color_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // flow_x [15:0], flow_y [31:16]
  input  logic        s_tlast,
  input  logic [0:0]  s_tuser,     // flow_unknown [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,     // red [7:0], green [15:8], blue [23:16]
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import fvc_pkg::*;

  localparam int Depth  = 2 + SqrtSteps + DivSteps + 4;
  localparam int TDelay = SqrtSteps + DivSteps - CordicSteps + 1;

  logic               ce;
  logic [15:0]        max_radius;
  logic [15:0]        mr_eff;
  logic [31:0]        mr2;
  meta_t              meta [Depth];
  meta_t              meta1_next;

  logic signed [15:0] fx;
  logic signed [15:0] fy;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic [31:0]        sqx;
  logic [31:0]        sqy;
  logic [31:0]        mag2;

  logic signed [31:0] cx [CordicSteps+1];
  logic signed [31:0] cy [CordicSteps+1];
  logic [19:0]        acc [CordicSteps+1];
  logic [15:0]        t_fix;
  logic [15:0]        t_line [TDelay];

  logic [47:0]        s_bits [SqrtSteps+1];
  logic [25:0]        s_rem [SqrtSteps+1];
  logic [23:0]        s_root [SqrtSteps+1];

  logic [16:0]        d_bits [DivSteps+1];
  logic [15:0]        d_rem [DivSteps+1];
  logic [16:0]        d_q [DivSteps+1];

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = meta[Depth-1].valid;
  assign m_tlast  = meta[Depth-1].last;
  assign fx       = s_tdata[15:0];
  assign fy       = s_tdata[31:16];
  assign xs       = {{4{fx[15]}}, fx, 12'b0};
  assign ys       = {{4{fy[15]}}, fy, 12'b0};
  assign mr_eff   = (max_radius == '0) ? 16'd1 : max_radius;
  assign mag2     = sqx + sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius <= MaxRadiusReset;
    end else if (cfg_wr_en) begin
      max_radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mr2 <= 32'(mr_eff) * 32'(mr_eff);
  end

  always_comb begin
    meta1_next           = meta[0];
    meta1_next.in_circle = (mag2 <= mr2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        meta[i].valid <= 1'b0;
      end
    end else if (ce) begin
      meta[0].valid     <= s_tvalid;
      meta[0].unknown   <= s_tuser[0];
      meta[0].last      <= s_tlast;
      meta[0].yzero     <= (fy == '0);
      meta[0].xneg      <= fx[15];
      meta[0].in_circle <= 1'b0;
      meta[1]           <= meta1_next;
      for (int i = 2; i < Depth; i++) begin
        meta[i] <= meta[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sqx <= 32'(32'(fx) * 32'(fx));
      sqy <= 32'(32'(fy) * 32'(fy));
      cx[0]  <= fx[15] ? -xs : xs;
      cy[0]  <= fx[15] ? -ys : ys;
      acc[0] <= fx[15] ? 20'h80000 : 20'h00000;
      s_bits[0] <= {mag2, 16'b0};
      s_rem[0]  <= '0;
      s_root[0] <= '0;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    fvc_cordic_cell #(.STAGE(i)) u_cell (
      .clk(clk), .ce(ce),
      .cx_in(cx[i]), .cy_in(cy[i]), .acc_in(acc[i]),
      .cx(cx[i+1]), .cy(cy[i+1]), .acc(acc[i+1])
    );
  end

  assign t_fix = meta[CordicSteps].yzero ? (meta[CordicSteps].xneg ? HalfTurn : 16'h0000)
                                         : acc[CordicSteps][19:4];

  always_ff @(posedge clk) begin
    if (ce) begin
      t_line[0] <= t_fix;
      for (int i = 1; i < TDelay; i++) begin
        t_line[i] <= t_line[i-1];
      end
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    fvc_sqrt_cell u_cell (
      .clk(clk), .ce(ce),
      .bits_in(s_bits[i]), .rem_in(s_rem[i]), .root_in(s_root[i]),
      .bits(s_bits[i+1]), .rem(s_rem[i+1]), .root(s_root[i+1])
    );
  end

  assign d_bits[0] = {s_root[SqrtSteps][8:0], 8'b0};
  assign d_rem[0]  = {1'b0, s_root[SqrtSteps][23:9]};
  assign d_q[0]    = '0;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    fvc_div_cell u_cell (
      .clk(clk), .ce(ce), .divisor(mr_eff),
      .bits_in(d_bits[i]), .rem_in(d_rem[i]), .q_in(d_q[i]),
      .bits(d_bits[i+1]), .rem(d_rem[i+1]), .q(d_q[i+1])
    );
  end

  fvc_shade u_shade (
    .clk(clk), .ce(ce),
    .turn(t_line[TDelay-1]),
    .rad(d_q[DivSteps]),
    .in_circle(meta[Depth-5].in_circle),
    .unknown(meta[Depth-5].unknown),
    .red(m_tdata[7:0]),
    .green(m_tdata[15:8]),
    .blue(m_tdata[23:16])
  );

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
      meta[SqrtSteps+1].valid && meta[SqrtSteps+1].in_circle
      |-> s_root[SqrtSteps] <= {mr_eff, 8'b0})
    else $error("Square root exceeds the radius inside the circle.");

  a_rad_bound: assert property (@(posedge clk) disable iff (rst)
      meta[Depth-5].valid && meta[Depth-5].in_circle |-> d_q[DivSteps] <= 17'h10000)
    else $error("Normalized radius above one inside the circle.");

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fvc_pkg::*;

  localparam int ColorLatency = 47;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } color_t;

  typedef struct {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic               unknown;
    logic               last;
    logic               has_rgb;
    logic [23:0]        rgb;
  } pixel_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  logic [15:0] radius_q88;
  color_t      color_queue[$];
  int          mismatch_count;
  longint      cycle_count;
  pixel_row_t  pixel_table[$];

  flow_vector_to_color_core DUT (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) begin
      return v >>> s;
    end
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] flow_direction(int x, int y);
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    logic [19:0] acc;
    int          angle_step[16];
    angle_step = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                   652, 326, 163, 81, 41, 20, 10, 5};
    if (y == 0) begin
      return (x < 0) ? 16'h8000 : 16'h0000;
    end
    acc = '0;
    cx = longint'(x) * 4096;
    cy = longint'(y) * 4096;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      acc = 20'h80000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        acc = acc + 20'(angle_step[i]);
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        acc = acc - 20'(angle_step[i]);
      end
    end
    return acc[19:4];
  endfunction

  function automatic logic [23:0] hue_entry(int k);
    int seg;
    int up;
    int dn;
    seg = (k / 15) % 6;
    up = 255 * (k % 15) / 15;
    dn = 255 - up;
    case (seg)
      0: return {8'd0, 8'(up), 8'd255};
      1: return {8'd0, 8'd255, 8'(dn)};
      2: return {8'(up), 8'd255, 8'd0};
      3: return {8'd255, 8'(dn), 8'd0};
      4: return {8'd255, 8'd0, 8'(up)};
      default: return {8'(dn), 8'd0, 8'd255};
    endcase
  endfunction

  function automatic color_t predict_color(logic signed [15:0] fx, logic signed [15:0] fy,
                                           logic unknown, logic last);
    color_t      res;
    longint      mr;
    longint      mag2;
    longint      rad;
    longint      fk;
    longint      c;
    longint      f;
    int          k0;
    int          k1;
    bit          in_circle;
    logic [23:0] e0;
    logic [23:0] e1;
    logic [7:0]  chan[3];
    res.frame_end = last;
    if (unknown) begin
      res.red = 0;
      res.green = 0;
      res.blue = 0;
      return res;
    end
    mr = (radius_q88 == 0) ? 1 : longint'(radius_q88);
    mag2 = longint'(fx) * fx + longint'(fy) * fy;
    in_circle = mag2 <= mr * mr;
    rad = 0;
    if (in_circle) begin
      rad = (int_sqrt(mag2 << 16) << 8) / mr;
      if (rad > 65536) rad = 65536;
    end
    fk = longint'(flow_direction(fx, fy)) * 89;
    k0 = int'((fk >> 16) % 90);
    k1 = (k0 + 1) % 90;
    f = fk & 16'hFFFF;
    e0 = hue_entry(k0);
    e1 = hue_entry(k1);
    for (int ch = 0; ch < 3; ch++) begin
      c = (65536 - f) * e0[8*ch +: 8] + f * e1[8*ch +: 8];
      if (in_circle) begin
        c = 255 * 65536 - ((rad * (255 * 65536 - c)) >> 16);
      end
      chan[ch] = 8'(c >> 16);
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic send_pixel(pixel_row_t p);
    color_t want;
    int     gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = predict_color(p.fx, p.fy, p.unknown, p.last);
    if (p.has_rgb) begin
      want.red = p.rgb[7:0];
      want.green = p.rgb[15:8];
      want.blue = p.rgb[23:16];
    end
    color_queue = {color_queue, want};
    s_tvalid <= 1'b1;
    s_tdata <= {p.fy, p.fx};
    s_tlast <= p.last;
    s_tuser <= p.unknown;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_radius(logic [15:0] value);
    s_tvalid <= 1'b0;
    wait (color_queue.size() == 0);
    repeat (ColorLatency + 5) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_q88 = value;
  endtask

  function automatic pixel_row_t pixel(int fx, int fy, bit unk, bit last,
                                       bit has_rgb = 0, logic [23:0] rgb = '0);
    pixel_row_t p;
    p.fx = 16'(fx);
    p.fy = 16'(fy);
    p.unknown = unk;
    p.last = last;
    p.has_rgb = has_rgb;
    p.rgb = rgb;
    return p;
  endfunction

  function automatic pixel_row_t random_pixel(int span);
    pixel_row_t p;
    int         sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      p = pixel($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span, 0, 0);
    end else if (sel < 8) begin
      p = pixel($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
    end else if (sel == 8) begin
      p = pixel($urandom_range(0, 65535), 0, 0, 0);
    end else begin
      p = pixel($urandom_range(0, 65535), $urandom_range(0, 65535), 1, 0);
    end
    p.last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  always @(posedge clk) begin
    color_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (color_queue.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = color_queue.pop_front();
        if (m_tdata[7:0] !== want.red) report_mismatch("red", m_tdata[7:0], want.red);
        if (m_tdata[15:8] !== want.green) report_mismatch("green", m_tdata[15:8], want.green);
        if (m_tdata[23:16] !== want.blue) report_mismatch("blue", m_tdata[23:16], want.blue);
        if (m_tlast !== want.frame_end) report_mismatch("frame_end", m_tlast, want.frame_end);
      end
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] radius_list[6];
    int          drain;
    radius_list = '{16'd7680, 16'd0, 16'd1, 16'd65535, 16'd256, 16'd3000};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    radius_q88 = 16'd7680;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pixel_table = {pixel_table, pixel(0, 0, 0, 0, 1, 24'hFFFFFF)};
    pixel_table = {pixel_table, pixel(100, 200, 1, 1, 1, 24'h000000)};
    pixel_table = {pixel_table, pixel(-32768, -32768, 1, 0, 1, 24'h000000)};
    pixel_table = {pixel_table, pixel(32767, 0, 0, 0, 1, 24'h0000FF)};
    pixel_table = {pixel_table, pixel(-32768, 0, 0, 1)};
    pixel_table = {pixel_table, pixel(0, 32767, 0, 0)};
    pixel_table = {pixel_table, pixel(0, -32768, 0, 0)};
    pixel_table = {pixel_table, pixel(32767, 32767, 0, 0)};
    pixel_table = {pixel_table, pixel(-32768, 32767, 0, 0)};
    pixel_table = {pixel_table, pixel(32767, -32768, 0, 0)};
    pixel_table = {pixel_table, pixel(-32768, -32768, 0, 1)};
    pixel_table = {pixel_table, pixel(7680, 0, 0, 0)};
    pixel_table = {pixel_table, pixel(3840, 0, 0, 0)};
    pixel_table = {pixel_table, pixel(-1, 0, 0, 0)};
    pixel_table = {pixel_table, pixel(1, 1, 0, 0)};
    pixel_table = {pixel_table, pixel(-1, -1, 0, 0)};
    pixel_table = {pixel_table, pixel(1000, -1, 0, 0)};
    pixel_table = {pixel_table, pixel(-1000, 1, 0, 1)};
    pixel_table = {pixel_table, pixel(-21845, -21846, 0, 0)};
    foreach (pixel_table[i]) send_pixel(pixel_table[i]);

    for (int phase = 0; phase < 6; phase++) begin
      write_radius(radius_list[phase]);
      send_pixel(pixel(0, 0, 0, 0));
      send_pixel(pixel(int'(radius_list[phase]), 0, 0, 1));
      for (int n = 0; n < 300; n++) begin
        send_pixel(random_pixel((radius_list[phase] < 16) ? 64 : int'(radius_list[phase]) + 64));
      end
    end
    write_radius(16'($urandom_range(1, 65535)));
    for (int n = 0; n < 40; n++) send_pixel(random_pixel(20000));

    s_tvalid <= 1'b0;
    wait (color_queue.size() == 0);
    drain = 0;
    while (drain < ColorLatency * 4) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0 && color_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
